>>> rtl/rrqd_pkg.sv
// ----------------------------------------------------------------------------
// rrqd_pkg
// shared types and codes of the round robin queue drain block
// ----------------------------------------------------------------------------
package rrqd_pkg;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic clear_write;
      logic capture;
      logic select;
      logic update;
      logic deliver;
   } rrqd_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic pop_hit;
   } rrqd_sts_type;

endpackage

>>> rtl/rrqd_ram.sv
// ----------------------------------------------------------------------------
// rrqd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rrqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rrqd_ctrl.sv
// ----------------------------------------------------------------------------
// rrqd_ctrl
// transaction sequencer: reset clearing pass, queue select, update, read
// ----------------------------------------------------------------------------
module rrqd_ctrl
   import rrqd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output rrqd_cmd_type cmd,
   input  rrqd_sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SELECT,
      S_UPDATE,
      S_READ
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_SELECT;
            end
         end
         S_SELECT: begin
            cmd.select = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            if (sts.pop_hit) begin
               state_in = S_READ;
            end else begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_READ: begin
            cmd.deliver = 1'b1;
            strobe_in   = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

>>> rtl/rrqd_datapath.sv
// ----------------------------------------------------------------------------
// rrqd_datapath
// queue storage, per-queue head and count table, occupancy bits, round robin
// selection and result registers
// ----------------------------------------------------------------------------
module rrqd_datapath
   import rrqd_pkg::*;
#(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  rrqd_cmd_type        cmd,
   output rrqd_sts_type        sts,
   input  logic                req_op,
   input  logic [2:0]          req_queue_index,
   input  logic signed [31:0]  req_value,
   output logic signed [31:0]  rsp_data_out,
   output logic [2:0]          rsp_source_queue,
   output logic [1:0]          rsp_status
);

   localparam int QW = $clog2(NUM_QUEUES);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int MW = PW + CW;
   localparam int SD = NUM_QUEUES * QUEUE_DEPTH;
   localparam int AW = $clog2(SD);

   // captured transaction
   logic                  op_ff;
   logic [2:0]            qi_ff;
   logic [DATA_WIDTH-1:0] word_ff;

   // control state
   logic [NUM_QUEUES-1:0] nonempty_ff;
   logic [QW-1:0]         next_ff;
   logic [QW-1:0]         clear_ff;
   logic [QW-1:0]         q_ff;
   logic                  hit_ff;

   // result registers
   logic [31:0] rsp_data_ff;
   logic [2:0]  rsp_queue_ff;
   logic [1:0]  rsp_status_ff;

   // selection
   logic [NUM_QUEUES-1:0] masked;
   logic [QW-1:0]         sel_high;
   logic [QW-1:0]         sel_any;
   logic [QW-1:0]         q_in;
   logic                  hit_in;
   logic [7:0]            qi_ext;

   // table and store access
   logic [MW-1:0] meta_rd;
   logic [PW-1:0] head;
   logic [CW-1:0] count;
   logic          full;
   logic [PW:0]   tail_sum;
   logic [PW-1:0] tail;
   logic [PW:0]   head_sum;
   logic [PW-1:0] head_next;
   logic          meta_wr_en;
   logic [QW-1:0] meta_wr_addr;
   logic [MW-1:0] meta_wr_data;
   logic          store_wr_en;
   logic          store_rd_en;
   logic [AW-1:0] base;
   logic [AW-1:0] store_wr_addr;
   logic [AW-1:0] store_rd_addr;
   logic [DATA_WIDTH-1:0] store_rd;
   logic [QW-1:0] q_plus;
   logic [7:0]    q_ext;

   always_comb begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         masked[i] = nonempty_ff[i] && (QW'(i) >= next_ff);
      end
      sel_high = '0;
      sel_any  = '0;
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         if (masked[i]) begin
            sel_high = QW'(i);
         end
         if (nonempty_ff[i]) begin
            sel_any = QW'(i);
         end
      end
   end

   assign qi_ext = {5'd0, qi_ff};

   always_comb begin
      if (op_ff == OP_POP) begin
         hit_in = |nonempty_ff;
         q_in   = (|masked) ? sel_high : sel_any;
      end else begin
         hit_in = ({29'd0, qi_ff} < 32'(NUM_QUEUES));
         q_in   = qi_ext[QW-1:0];
      end
   end

   assign head  = meta_rd[MW-1:CW];
   assign count = meta_rd[CW-1:0];
   assign full  = (count == CW'(QUEUE_DEPTH));

   assign tail_sum  = (PW+1)'(head) + (PW+1)'(count);
   assign tail      = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                      PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
   assign head_sum  = (PW+1)'(head) + (PW+1)'(1);
   assign head_next = (head_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                      PW'(head_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(head_sum);

   assign base          = AW'(q_ff) * AW'(QUEUE_DEPTH);
   assign store_wr_addr = base + AW'(tail);
   assign store_rd_addr = base + AW'(head);

   assign q_plus = (q_ff == QW'(NUM_QUEUES - 1)) ? '0 : q_ff + QW'(1);
   assign q_ext  = 8'(q_ff);

   always_comb begin
      meta_wr_en   = 1'b0;
      meta_wr_addr = q_ff;
      meta_wr_data = '0;
      store_wr_en  = 1'b0;
      store_rd_en  = 1'b0;
      if (cmd.clear_write) begin
         meta_wr_en   = 1'b1;
         meta_wr_addr = clear_ff;
      end else if (cmd.update && hit_ff) begin
         if (op_ff == OP_POP) begin
            meta_wr_en   = 1'b1;
            meta_wr_data = {head_next, count - CW'(1)};
            store_rd_en  = 1'b1;
         end else if (!full) begin
            meta_wr_en   = 1'b1;
            meta_wr_data = {head, count + CW'(1)};
            store_wr_en  = 1'b1;
         end
      end
   end

   rrqd_ram #(
      .WIDTH (MW),
      .DEPTH (NUM_QUEUES)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (cmd.select),
      .rd_addr (q_in),
      .rd_data (meta_rd)
   );

   rrqd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (SD)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (word_ff),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         qi_ff   <= req_queue_index;
         word_ff <= DATA_WIDTH'($unsigned(req_value));
      end
      if (cmd.select) begin
         q_ff <= q_in;
      end
      if (cmd.update) begin
         rsp_data_ff <= '0;
         if (op_ff == OP_POP) begin
            if (hit_ff) begin
               rsp_queue_ff  <= q_ext[2:0];
               rsp_status_ff <= STATUS_OK;
            end else begin
               rsp_queue_ff  <= '0;
               rsp_status_ff <= STATUS_EMPTY;
            end
         end else begin
            rsp_queue_ff  <= '0;
            rsp_status_ff <= (!hit_ff || full) ? STATUS_FULL : STATUS_OK;
         end
      end
      if (cmd.deliver) begin
         rsp_data_ff <= 32'(store_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
         next_ff     <= '0;
         clear_ff    <= '0;
         hit_ff      <= 1'b0;
      end else begin
         if (cmd.clear_write) begin
            clear_ff <= clear_ff + QW'(1);
         end
         if (cmd.select) begin
            hit_ff <= hit_in;
         end
         if (cmd.update && hit_ff) begin
            if (op_ff == OP_POP) begin
               next_ff <= q_plus;
               if (count == CW'(1)) begin
                  nonempty_ff[q_ff] <= 1'b0;
               end
            end else if (!full) begin
               nonempty_ff[q_ff] <= 1'b1;
            end
         end
      end
   end

   assign sts.clear_last = (clear_ff == QW'(NUM_QUEUES - 1));
   assign sts.pop_hit    = (op_ff == OP_POP) && hit_ff;

   assign rsp_data_out     = $signed(rsp_data_ff);
   assign rsp_source_queue = rsp_queue_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> rtl/round_robin_queue_drain.sv
// ----------------------------------------------------------------------------
// round_robin_queue_drain
// set of fifo queues with push by queue index and round robin pop
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Push and failed
// transactions do one read of the head/count table, and a successful pop also
// does one read of the queue store. Busy drops on the cycle the result appears,
// so a new transaction can be taken only once the previous result appears. The
// result is shown for exactly one cycle with rsp_strobe high and cannot be held
// off. After reset, busy stays high while the head/count table is cleared.
// ----------------------------------------------------------------------------
module round_robin_queue_drain
   import rrqd_pkg::*;
#(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [2:0]         req_queue_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_data_out,
   output logic [2:0]         rsp_source_queue,
   output logic [1:0]         rsp_status
);

   rrqd_cmd_type cmd;
   rrqd_sts_type sts;

   rrqd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .sts        (sts)
   );

   rrqd_datapath #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_op),
      .req_queue_index  (req_queue_index),
      .req_value        (req_value),
      .rsp_data_out     (rsp_data_out),
      .rsp_source_queue (rsp_source_queue),
      .rsp_status       (rsp_status)
   );

endmodule
